// ===== hdl/mcd_pkg.sv =====
// Shared types and constants for the tracker pattern cell decoder.
// Holds the period table, note codes and effect numbers; no dependencies.
package mcd_pkg;

  // Period table: three octaves, highest period (lowest pitch) first
  localparam int PERIOD_COUNT = 36;
  localparam int IDX_W        = $clog2(PERIOD_COUNT);
  localparam int PERIOD_W     = 12;

  localparam logic [PERIOD_W-1:0] PERIOD_TABLE [PERIOD_COUNT] = '{
    12'd856, 12'd808, 12'd762, 12'd720, 12'd678, 12'd640,
    12'd604, 12'd570, 12'd538, 12'd508, 12'd480, 12'd453,
    12'd428, 12'd404, 12'd381, 12'd360, 12'd339, 12'd320,
    12'd302, 12'd285, 12'd269, 12'd254, 12'd240, 12'd226,
    12'd214, 12'd202, 12'd190, 12'd180, 12'd170, 12'd160,
    12'd151, 12'd143, 12'd135, 12'd127, 12'd120, 12'd113
  };

  // Note codes
  localparam int         NOTE_BASE  = 60;
  localparam logic [7:0] NOTE_FIRST = 8'(NOTE_BASE - 12);
  localparam logic [7:0] NOTE_NONE  = 8'd255;

  // Effect numbers (low nibble of the sample byte)
  localparam logic [3:0] EFF_ARPEGGIO   = 4'h0;
  localparam logic [3:0] EFF_PORTA_UP   = 4'h1;
  localparam logic [3:0] EFF_PORTA_DOWN = 4'h2;
  localparam logic [3:0] EFF_TONE_PORTA = 4'h3;
  localparam logic [3:0] EFF_VIBRATO    = 4'h4;
  localparam logic [3:0] EFF_VOL_SLIDE  = 4'hA;
  localparam logic [3:0] EFF_SET_VOLUME = 4'hC;
  localparam logic [3:0] EFF_EXTENDED   = 4'hE;
  localparam logic [3:0] EFF_SPEED      = 4'hF;

  // Extended sub-commands that are kept (fine volume slide up / down)
  localparam logic [3:0] EXT_FINE_VOL_UP   = 4'hA;
  localparam logic [3:0] EXT_FINE_VOL_DOWN = 4'hB;

  // Largest speed value that passes
  localparam logic [7:0] SPEED_MAX = 8'd31;

  // Result of the period lookup
  typedef struct packed {
    logic [7:0] note;
    logic       found;
  } note_res_t;

endpackage

// ===== hdl/mcd_note_lookup.sv =====
// Period to note lookup for the cell decoder.
// Compares the 12-bit period against all table entries in parallel; uses mcd_pkg.
module mcd_note_lookup (
  input  logic [mcd_pkg::PERIOD_W-1:0] period_i,
  output mcd_pkg::note_res_t           res_o
);

  logic [mcd_pkg::IDX_W-1:0] idx;
  logic                      hit;

  // Match against every entry; the lowest matching index wins
  always_comb begin
    idx = '0;
    hit = 1'b0;
    for (int i = mcd_pkg::PERIOD_COUNT - 1; i >= 0; i--) begin
      if (mcd_pkg::PERIOD_TABLE[i] == period_i) begin
        idx = mcd_pkg::IDX_W'(i);
        hit = 1'b1;
      end
    end
  end

  // Zero period never counts as a note
  always_comb begin
    res_o.found = hit && (period_i != '0);
    res_o.note  = res_o.found ? (8'(idx) + mcd_pkg::NOTE_FIRST) : mcd_pkg::NOTE_NONE;
  end

endmodule

// ===== hdl/mcd_cmd_remap.sv =====
// Effect command remap for the cell decoder.
// Scales volume and slide parameters with saturation, drops unsupported effects; uses mcd_pkg.
module mcd_cmd_remap (
  input  logic [3:0]  effect_i,
  input  logic [7:0]  param_i,
  output logic [11:0] command_o
);

  logic [3:0] hi;
  logic [3:0] lo;
  logic [3:0] hi_x2;
  logic [3:0] lo_x2;
  logic [7:0] p_x2;
  logic [7:0] p_x8;

  assign hi = param_i[7:4];
  assign lo = param_i[3:0];

  // Doubling and times-eight with saturation
  assign hi_x2 = hi[3] ? 4'hF : {hi[2:0], 1'b0};
  assign lo_x2 = lo[3] ? 4'hF : {lo[2:0], 1'b0};
  assign p_x2  = param_i[7] ? 8'hFF : {param_i[6:0], 1'b0};
  assign p_x8  = (param_i[7:5] != 3'd0) ? 8'hFF : {param_i[4:0], 3'b000};

  // Select the remapped command per effect
  always_comb begin
    case (effect_i)
      mcd_pkg::EFF_ARPEGGIO,
      mcd_pkg::EFF_VIBRATO: begin
        command_o = {effect_i, param_i};
      end
      mcd_pkg::EFF_PORTA_UP,
      mcd_pkg::EFF_PORTA_DOWN,
      mcd_pkg::EFF_TONE_PORTA: begin
        command_o = {effect_i, p_x8};
      end
      mcd_pkg::EFF_SET_VOLUME: begin
        command_o = {mcd_pkg::EFF_SET_VOLUME, p_x2};
      end
      mcd_pkg::EFF_VOL_SLIDE: begin
        command_o = {mcd_pkg::EFF_VOL_SLIDE, hi_x2, lo_x2};
      end
      mcd_pkg::EFF_EXTENDED: begin
        if (hi == mcd_pkg::EXT_FINE_VOL_UP || hi == mcd_pkg::EXT_FINE_VOL_DOWN) begin
          command_o = {mcd_pkg::EFF_EXTENDED, hi, lo_x2};
        end else begin
          command_o = '0;
        end
      end
      mcd_pkg::EFF_SPEED: begin
        command_o = (param_i <= mcd_pkg::SPEED_MAX) ? {mcd_pkg::EFF_SPEED, param_i} : '0;
      end
      default: begin
        command_o = '0;
      end
    endcase
  end

endmodule

// ===== hdl/mod_cell_decoder.sv =====
// Top level of the tracker pattern cell decoder: input register, decode, result register.
// Instantiates mcd_note_lookup and mcd_cmd_remap; uses mcd_pkg.
//
// Decodes one four-byte pattern cell per word into note, note_found, instrument and
// command. One cell is accepted every clock cycle unless backpressure on the output stalls
// the input. The cell is captured in the input register, runs a single pass of table
// compares and saturating arithmetic, and is caught by the result register. Both
// channels use valid/ready. While a finished word waits at the output, the input stays
// ready as long as the input register is free, and backpressure on the output stalls
// the two stages in turn. There is no configuration and no state beyond the pipeline.
module mod_cell_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] period_word_i,
  input  logic [7:0]  sample_byte_i,
  input  logic [7:0]  effect_param_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  note_o,
  output logic        note_found_o,
  output logic [7:0]  instrument_o,
  output logic [11:0] command_o
);

  // Input register
  logic        in_valid_q;
  logic [15:0] pw_q;
  logic [7:0]  sb_q;
  logic [7:0]  ep_q;

  // Result register
  logic        out_valid_q;
  logic [7:0]  note_q;
  logic        found_q;
  logic [7:0]  instr_q;
  logic [11:0] cmd_q;

  logic                res_take;
  mcd_pkg::note_res_t  note_res;
  logic [7:0]          instr_d;
  logic [11:0]         cmd_d;

  // Result stage can load when empty or being drained
  assign res_take   = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || res_take;

  // Hold or load the input word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pw_q <= period_word_i;
      sb_q <= sample_byte_i;
      ep_q <= effect_param_i;
    end
  end

  // Decode
  mcd_note_lookup u_note_lookup (
    .period_i (pw_q[11:0]),
    .res_o    (note_res)
  );

  mcd_cmd_remap u_cmd_remap (
    .effect_i  (sb_q[3:0]),
    .param_i   (ep_q),
    .command_o (cmd_d)
  );

  // Instrument number minus one, wrapping
  assign instr_d = {pw_q[15:12], sb_q[7:4]} - 8'd1;

  // Advance the decoded word into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take && in_valid_q) begin
      note_q  <= note_res.note;
      found_q <= note_res.found;
      instr_q <= instr_d;
      cmd_q   <= cmd_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign note_o       = note_q;
  assign note_found_o = found_q;
  assign instrument_o = instr_q;
  assign command_o    = cmd_q;

`ifndef ASSERT_OFF
  logic [7:0] note_idx_chk;
  assign note_idx_chk = note_o - mcd_pkg::NOTE_FIRST;

  // A held input word moves to the output whenever the result stage frees up
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && res_take) |=> out_valid_o)
    else $error("decoded word not advanced to result register");

  // Input stalls only when its register is occupied
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without backpressure");

  // No match gives the no-note code
  a_no_note: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !note_found_o) |-> (note_o == mcd_pkg::NOTE_NONE))
    else $error("missing note without no-note code");

  // A matched note lies within the table range
  a_note_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && note_found_o) |-> (note_idx_chk < 8'(mcd_pkg::PERIOD_COUNT)))
    else $error("matched note outside table range");

  // A nonzero command carries a supported effect number
  a_cmd_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && command_o != '0) |->
      (command_o[11:8] == mcd_pkg::EFF_ARPEGGIO || command_o[11:8] == mcd_pkg::EFF_PORTA_UP ||
       command_o[11:8] == mcd_pkg::EFF_PORTA_DOWN || command_o[11:8] == mcd_pkg::EFF_TONE_PORTA ||
       command_o[11:8] == mcd_pkg::EFF_VIBRATO || command_o[11:8] == mcd_pkg::EFF_VOL_SLIDE ||
       command_o[11:8] == mcd_pkg::EFF_SET_VOLUME || command_o[11:8] == mcd_pkg::EFF_EXTENDED ||
       command_o[11:8] == mcd_pkg::EFF_SPEED))
    else $error("unsupported effect number in command");
`endif

endmodule
